>>> hw/rtl/tcts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcts_pkg;

  localparam int unsigned DIVD_W = 36;
  localparam int unsigned DIVS_W = 16;
  localparam int unsigned STEP_W = 6;

  localparam logic [STEP_W-1:0] STEPS_SECONDS = 6'd32;
  localparam logic [STEP_W-1:0] STEPS_MICROS  = 6'd36;

  localparam logic [31:0] DRIFT_LIMIT_SECONDS = 32'd10;
  localparam logic [19:0] MICROS_PER_SECOND   = 20'd1000000;

  localparam logic [15:0] TPS_RESET   = 16'd100;
  localparam logic [31:0] EPOCH_RESET = 32'd2082844800;

  // Register word index, taken from paddr[2]
  localparam logic REG_TICKS_PER_SECOND = 1'b0;
  localparam logic REG_EPOCH_OFFSET     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SEC,
    ST_DIFF,
    ST_CHECK,
    ST_MUL,
    ST_DIV_USEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIVS_W-1:0] remainder;
  } div_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/tick_clock_time_of_day_sync.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------
// in        | in_valid / in_ready        | in_rtc_seconds[31:0], in_tick_count[31:0]
// out       | out_valid / out_ready      | out_unix_seconds[31:0],
//           |                            | out_microseconds[19:0], out_resynced
// cfg (APB) | psel, penable, pwrite,     | paddr[2:0], pwdata[31:0] / prdata[31:0]
//           | pready (tied high)         |
//
// A request goes from acceptance to the result register through two
// passes of the shared bit-serial divider (32 steps for whole seconds, 36
// for microseconds) and the DIFF, CHECK, MUL, DONE states. in_ready is high
// only in idle, so a new request starts after the previous result is loaded.
// A result waiting on out_ready holds the sequencer in its last state only if
// the output register is still full; otherwise it frees the block at once.
// rst_n is synchronous: it clears the offset to zero and restores the
// register defaults (100 ticks/s, 2082844800 s epoch offset).
module tick_clock_time_of_day_sync
  import tcts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [31:0] in_rtc_seconds,
  input  wire logic [31:0] in_tick_count,
  // result channel
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_unix_seconds,
  output      logic [19:0] out_microseconds,
  output      logic        out_resynced,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] tps_r;
  logic [31:0] epoch_r;
  logic        cfg_wr;

  // persistent state
  logic [31:0] offset_r;

  // per-request working registers
  logic [31:0] rtc_r;
  logic [15:0] rate_r;
  logic [31:0] whole_r;
  logic [15:0] left_r;
  logic [31:0] estimate_r;
  logic [31:0] diff_r;
  logic [31:0] unix_r;
  logic        resync_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_unix_r;
  logic [19:0] out_usec_r;
  logic        out_resync_r;
  logic        out_load;

  // shared divider
  div_cmd_t          div_cmd;
  div_sts_t          div_sts;
  logic [DIVD_W-1:0] div_dividend;
  logic [15:0]       rate_in;
  logic [DIVS_W-1:0] div_divisor;
  logic [DIVD_W-1:0] micro_prod;

  logic [31:0] mag;
  logic        drift;

  // ---------------------------------------------------------------------
  // Configuration registers: write on the APB access phase
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r   <= TPS_RESET;
      epoch_r <= EPOCH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TICKS_PER_SECOND: tps_r   <= pwdata[15:0];
        REG_EPOCH_OFFSET:     epoch_r <= pwdata;
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TICKS_PER_SECOND: prdata = {16'd0, tps_r};
      REG_EPOCH_OFFSET:     prdata = epoch_r;
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DIV_SEC;
      ST_DIV_SEC:  if (div_sts.done) state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_DIV_USEC;
      ST_DIV_USEC: if (div_sts.done) state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  // A zero tick rate counts as one tick per second.
  assign rate_in    = (tps_r == 16'd0) ? 16'd1 : tps_r;
  // leftover ticks scaled to microseconds; registered inside the divider
  assign micro_prod = {20'd0, left_r} * DIVD_W'(MICROS_PER_SECOND);

  always_comb begin
    in_ready      = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.steps = STEPS_SECONDS;
    div_dividend  = {in_tick_count, 4'd0};
    div_divisor   = rate_in;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        div_cmd.start = in_valid;
      end
      ST_MUL: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = STEPS_MICROS;
        div_dividend  = micro_prod;
        div_divisor   = rate_r;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  tcts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts)
  );

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  // Drift magnitude: the most negative difference still reads as 2^31.
  assign mag   = diff_r[31] ? (32'd0 - diff_r) : diff_r;
  assign drift = (mag > DRIFT_LIMIT_SECONDS);

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        rtc_r  <= in_rtc_seconds;
        rate_r <= rate_in;
      end
      ST_DIV_SEC: begin
        whole_r    <= div_sts.quotient[31:0];
        left_r     <= div_sts.remainder;
        estimate_r <= div_sts.quotient[31:0] + offset_r;
      end
      ST_DIFF: begin
        diff_r <= rtc_r - estimate_r;
      end
      ST_CHECK: begin
        resync_r <= drift;
        if (drift) begin
          // snap the estimate to the clock reading and drop the fraction
          estimate_r <= rtc_r;
          left_r     <= 16'd0;
        end
      end
      ST_MUL: begin
        unix_r <= estimate_r - epoch_r;
      end
      default: ;
    endcase
  end

  // Re-synchronize the stored offset on excessive drift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 32'd0;
    end else if (state_r == ST_CHECK && drift) begin
      offset_r <= rtc_r - whole_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_unix_r   <= unix_r;
      out_usec_r   <= div_sts.quotient[19:0];
      out_resync_r <= resync_r;
    end
  end

  // The microsecond quotient stays in the divider until the next start,
  // which cannot come before the result register is loaded.
  assign out_valid        = out_valid_r;
  assign out_unix_seconds = out_unix_r;
  assign out_microseconds = out_usec_r;
  assign out_resynced     = out_resync_r;

endmodule

`default_nettype wire

>>> hw/rtl/tcts_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is aligned to
// the MSB; after N steps the quotient sits in the low N bits.
module tcts_div
  import tcts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_cmd_t          cmd,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output      div_sts_t          sts
);

  logic [DIVD_W-1:0] q_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIVS_W:0]   rem_sh;
  logic              ge;
  logic [DIVS_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIVD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  assign sts.done      = done_r;
  assign sts.quotient  = q_r;
  assign sts.remainder = rem_r;

endmodule

`default_nettype wire

>>> hw/rtl/tcts_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module tcts_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_unix_seconds,
  input wire logic [19:0] out_microseconds,
  input wire logic        out_resynced,
  input wire logic        pready
);

  // one request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high in the cycle after a request was accepted");

  // a resync drops the sub-second fraction
  a_resync_zero_usec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resynced |-> out_microseconds == 20'd0)
    else $error("resynced result carries a nonzero microsecond value");

  a_usec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_microseconds < 20'd1000000)
    else $error("microseconds out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unix_seconds)
      && $stable(out_microseconds) && $stable(out_resynced))
    else $error("stalled result changed or dropped");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind tick_clock_time_of_day_sync tcts_chk u_tcts_chk (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcts_pkg::*;

  // End the run as failed if no request or result moves for this many cycles.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Long receiver hold-off, long enough to fill the block and stall its input.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Drain time after the last result: a full request latency and some margin.
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned ITEMS_PER_PHASE = 225;

  localparam logic [2:0] ADDR_TICKS_PER_SECOND = {REG_TICKS_PER_SECOND, 2'b00};
  localparam logic [2:0] ADDR_EPOCH_OFFSET     = {REG_EPOCH_OFFSET, 2'b00};

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [19:0] microseconds;
    logic        resynced;
  } tod_result_t;

  // Time-of-day predictor plus the queue of results still owed by the block.
  class tod_scoreboard;
    logic [15:0] ticks_per_second;
    logic [31:0] epoch_offset;
    logic [31:0] seconds_offset;
    tod_result_t owed[$];
    int unsigned mismatches;

    function new();
      ticks_per_second = TPS_RESET;
      epoch_offset     = EPOCH_RESET;
      seconds_offset   = 32'd0;
      mismatches       = 0;
    endfunction

    // A rate of zero divides as one.
    function logic [31:0] tick_rate();
      return (ticks_per_second == 16'd0) ? 32'd1 : {16'd0, ticks_per_second};
    endfunction

    function logic [31:0] estimate_for(logic [31:0] ticks);
      return ticks / tick_rate() + seconds_offset;
    endfunction

    task note_request(input logic [31:0] rtc, input logic [31:0] ticks);
      logic [31:0] rate;
      logic [31:0] whole;
      logic [31:0] left;
      logic [31:0] estimate;
      logic [31:0] drift;
      logic [31:0] magnitude;
      logic [63:0] micros;
      tod_result_t r;
      rate      = tick_rate();
      whole     = ticks / rate;
      left      = ticks % rate;
      estimate  = whole + seconds_offset;
      drift     = rtc - estimate;
      magnitude = drift[31] ? (32'd0 - drift) : drift;
      r.resynced = 1'b0;
      if (magnitude > DRIFT_LIMIT_SECONDS) begin
        seconds_offset = rtc - whole;
        estimate       = rtc;
        left           = 32'd0;
        r.resynced     = 1'b1;
      end
      micros = ({32'd0, left} * {44'd0, MICROS_PER_SECOND}) / {32'd0, rate};
      r.unix_seconds = estimate - epoch_offset;
      r.microseconds = micros[19:0];
      owed.push_back(r);
    endtask

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(input tod_result_t got);
      tod_result_t want;
      if (owed.size() == 0) begin
        report_mismatch("result with no request pending", {11'd0, got}, 64'd0);
      end else begin
        want = owed.pop_front();
        if (got.unix_seconds !== want.unix_seconds)
          report_mismatch("unix_seconds", 64'(got.unix_seconds), 64'(want.unix_seconds));
        if (got.microseconds !== want.microseconds)
          report_mismatch("microseconds", 64'(got.microseconds), 64'(want.microseconds));
        if (got.resynced !== want.resynced)
          report_mismatch("resynced", 64'(got.resynced), 64'(want.resynced));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_rtc_seconds;
  logic [31:0] in_tick_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_unix_seconds;
  logic [19:0] out_microseconds;
  logic        out_resynced;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tick_clock_time_of_day_sync dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rtc_seconds   (in_rtc_seconds),
    .in_tick_count    (in_tick_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_unix_seconds (out_unix_seconds),
    .out_microseconds (out_microseconds),
    .out_resynced     (out_resynced),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  tod_scoreboard sb = new();

  // The first two are shared between the request and result processes.
  bit          no_idle;     // both sides skip their random waits
  bit          hold_off_req; // receiver takes one long hold-off at its next draw
  logic [31:0] last_ticks;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count cycles with no handshake on either channel; a hung block ends the run here.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: draw a stall per result, raise ready, and check what comes out.
  initial begin
    int unsigned stall;
    tod_result_t got;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall != 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      // out_ready is high from here on, so a high out_valid means acceptance.
      do @(posedge clk); while (out_valid !== 1'b1);
      got.unix_seconds = out_unix_seconds;
      got.microseconds = out_microseconds;
      got.resynced     = out_resynced;
      sb.check_result(got);
    end
  end

  // One APB transfer: setup cycle, access cycle, then release the bus.
  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register, then read it back; only the bits under mask are compared.
  task automatic set_register(input logic [2:0] addr, input logic [31:0] data,
                              input logic [31:0] mask);
    logic [31:0] rdata;
    apb_access(1'b1, addr, data, rdata);
    apb_access(1'b0, addr, 32'd0, rdata);
    if ((rdata & mask) !== (data & mask))
      sb.report_mismatch("register readback", 64'(rdata & mask), 64'(data & mask));
  endtask

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input logic [31:0] rtc, input logic [31:0] ticks);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_rtc_seconds <= rtc;
    in_tick_count  <= ticks;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(rtc, ticks);
    last_ticks = ticks;
  endtask

  // Place the clock reading a chosen distance (mod 2^32) from the current estimate.
  task automatic send_with_drift(input logic [31:0] ticks, input logic [31:0] drift);
    send_request(sb.estimate_for(ticks) + drift, ticks);
  endtask

  task automatic stop_requests();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Mostly a steady clock with small jitter around the drift limit, plus noise,
  // big jumps that force a resync, and the wraparound corners of the drift test.
  task automatic send_random_item();
    int unsigned pick;
    logic [31:0] rate;
    logic [31:0] ticks;
    logic [31:0] drift;
    rate = sb.tick_rate();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      ticks = last_ticks + $urandom_range(0, 4 * rate);
      drift = $urandom_range(0, 24) - 12;
      send_with_drift(ticks, drift);
    end else if (pick < 85) begin
      send_request($urandom, $urandom);
    end else if (pick < 95) begin
      drift = $urandom_range(13, 5000);
      if ($urandom_range(0, 1) == 1)
        drift = 32'd0 - drift;
      if ($urandom_range(0, 1) == 1)
        ticks = last_ticks + $urandom_range(0, 4 * rate);
      else
        ticks = last_ticks - $urandom_range(0, 4 * rate);
      send_with_drift(ticks, drift);
    end else begin
      ticks = $urandom;
      case ($urandom_range(0, 3))
        0: drift = 32'h8000_0000;
        1: drift = 32'h7FFF_FFFF;
        2: drift = 32'h8000_0001;
        default: drift = 32'hFFFF_FFF6;
      endcase
      send_with_drift(ticks, drift);
    end
  endtask

  // Drain, reprogram both registers while idle, then run a burst of random requests.
  task automatic run_phase(input logic [15:0] tps, input logic [31:0] epoch,
                           input bit quiet, input bit long_hold);
    logic [31:0] word;
    wait_for_results();
    repeat (4) @(negedge clk);
    // Random upper bits check that only 16 bits of the rate are kept.
    word = $urandom;
    word[15:0] = tps;
    set_register(ADDR_TICKS_PER_SECOND, word, 32'h0000_FFFF);
    sb.ticks_per_second = tps;
    set_register(ADDR_EPOCH_OFFSET, epoch, 32'hFFFF_FFFF);
    sb.epoch_offset = epoch;
    no_idle = quiet;
    if (long_hold)
      hold_off_req = 1'b1;
    repeat (ITEMS_PER_PHASE) send_random_item();
    stop_requests();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rtc_seconds = 32'd0;
    in_tick_count  = 32'd0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 3'd0;
    pwdata         = 32'd0;
    no_idle        = 1'b0;
    hold_off_req   = 1'b0;
    last_ticks     = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed requests under the reset defaults (100 ticks/s, zero offset).
    send_request(32'd0, 32'd0);             // no drift at tick zero
    send_with_drift(32'd0, 32'd10);         // exactly at the limit: keep offset
    send_with_drift(32'd0, 32'd11);         // just past the limit: resync
    send_with_drift(32'd99, 32'd0);         // largest leftover tick count
    send_with_drift(32'd1000, 32'hFFFF_FFF6); // minus ten: keep offset
    send_with_drift(32'd1000, 32'hFFFF_FFF5); // minus eleven: resync
    send_with_drift(32'd5000, 32'h8000_0000); // most negative drift resyncs
    send_with_drift(32'd5000, 32'h7FFF_FFFF); // most positive drift
    send_with_drift(32'd5050, 32'd0);
    send_with_drift(32'hFFFF_FFFF, 32'd0);  // tick counter at its top
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd0);
    send_with_drift(32'd7, 32'd5);          // clock reading wraps past 2^32
    send_request(32'd0, 32'hFFFF_FFFF);
    send_with_drift(32'hFFFF_FF9B, 32'hFFFF_FFFD);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_with_drift(32'h1234_5678, 32'd1);
    stop_requests();

    // Register settings, extremes first; the pause at each phase start drains the block.
    run_phase(16'd1,     32'd0,          1'b0, 1'b0);
    run_phase(16'hFFFF,  32'hFFFF_FFFF,  1'b0, 1'b0);
    run_phase(16'd0,     $urandom,       1'b0, 1'b0); // zero rate divides as one
    run_phase(16'd1000,  EPOCH_RESET,    1'b1, 1'b0); // back to back, no idling
    run_phase(16'($urandom), $urandom,   1'b0, 1'b1); // receiver holds off for a while
    run_phase(16'd100,   $urandom,       1'b0, 1'b0);
    run_phase(16'($urandom_range(2, 50)), $urandom, 1'b0, 1'b0);
    run_phase(16'($urandom), $urandom,   1'b1, 1'b0);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
